### src/ptss_pkg.sv
`default_nettype none
package ptss_pkg;

  localparam int DataW  = 16;
  localparam int KindW  = 2;
  localparam int CauseW = 2;
  localparam int CfgIdxW = 3;

  typedef enum logic [KindW-1:0] {
    KIND_START = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_STOP  = 2'd2
  } kind_t;

  typedef enum logic [CauseW-1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_ALARM = 2'd1,
    CAUSE_DONE  = 2'd2
  } cause_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHANNEL_ENABLE  = 3'd0,
    REG_LOW_TIME        = 3'd1,
    REG_HIGH_TIME       = 3'd2,
    REG_MAX_PULSES      = 3'd3,
    REG_INITIAL_COUNT   = 3'd4,
    REG_ALARM_STOP_TIME = 3'd5,
    REG_LOW_LEVEL       = 3'd6,
    REG_HIGH_LEVEL      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DataW-1:0]  drive;
    logic [DataW-1:0]  pulse_count;
    logic              running;
    logic [CauseW-1:0] shutdown_cause;
  } result_t;

endpackage
`default_nettype wire

### src/pulse_train_with_safety_stop.sv
// Results are registered: a beat's result enters the output register, or the skid register if that is stalled.
// Throughput: one input beat per cycle while in_ready is high; the channel state settles in the accept cycle.
// A two-entry result buffer (output register plus skid register) lets input beats be
// taken while a result waits; in_ready drops only once both entries are full.
// Reset (rst_n low, synchronous) clears the configuration registers, run state,
// accumulators and the result buffer's valid flags; result payloads are left as they are.
`default_nettype none
module pulse_train_with_safety_stop #(
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata,
  // command / tick beats
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_elapsed_ms,
  input  wire logic        in_safety_low,
  // result beats
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_drive,
  output logic [15:0]      out_pulse_count,
  output logic             out_running,
  output logic [1:0]       out_shutdown_cause
);

  // compare width: one spare bit over the accumulators so low_time + high_time
  // and the saturating sums never wrap
  localparam int CmpW = TIME_BITS + 1;
  localparam logic [TIME_BITS-1:0] TimeMax = '1;

  // configuration registers
  logic                      channel_enable_r;
  logic [ptss_pkg::DataW-1:0] low_time_r, high_time_r, max_pulses_r;
  logic [ptss_pkg::DataW-1:0] alarm_stop_time_r, low_level_r, high_level_r;

  // channel state
  logic                       run_active_r, run_active_nxt;
  logic [TIME_BITS-1:0]       phase_time_r, phase_time_nxt;
  logic [TIME_BITS-1:0]       alarm_time_r, alarm_time_nxt;
  logic [ptss_pkg::DataW-1:0] pulses_done_r, pulses_done_nxt;
  logic [ptss_pkg::DataW-1:0] drive_value_r, drive_value_nxt;

  // result buffer
  ptss_pkg::result_t out_r, skid_r, res_c;
  logic              out_valid_r, skid_valid_r;

  logic push, pop;

  // Saturating accumulator add.
  function automatic logic [TIME_BITS-1:0] sat_add(
    input logic [TIME_BITS-1:0]       a,
    input logic [ptss_pkg::DataW-1:0] b
  );
    logic [CmpW-1:0] sum;
    sum = CmpW'(a) + CmpW'(b);
    if (sum[TIME_BITS]) begin
      return TimeMax;
    end
    return sum[TIME_BITS-1:0];
  endfunction

  assign in_ready = !skid_valid_r;
  assign push     = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // Next channel state for the beat being accepted.
  always_comb begin
    logic [TIME_BITS-1:0] phase_sum;
    logic [TIME_BITS-1:0] alarm_sum;
    logic [CmpW-1:0]      lh_end;
    logic                 alarm;
    ptss_pkg::cause_t     cause;

    run_active_nxt  = run_active_r;
    phase_time_nxt  = phase_time_r;
    alarm_time_nxt  = alarm_time_r;
    pulses_done_nxt = pulses_done_r;
    drive_value_nxt = drive_value_r;
    cause           = ptss_pkg::CAUSE_NONE;
    alarm           = 1'b0;

    phase_sum = sat_add(phase_time_r, in_elapsed_ms);
    alarm_sum = sat_add(alarm_time_r, in_elapsed_ms);
    lh_end    = CmpW'(low_time_r) + CmpW'(high_time_r);

    if (push) begin
      unique case (in_kind)
        ptss_pkg::KIND_START: begin
          run_active_nxt = 1'b1;
        end
        ptss_pkg::KIND_STOP: begin
          run_active_nxt = 1'b0;
        end
        ptss_pkg::KIND_TICK: begin
          if (run_active_r) begin
            phase_time_nxt = phase_sum;
            if (channel_enable_r && (pulses_done_r < max_pulses_r)) begin
              if (CmpW'(phase_sum) <= CmpW'(low_time_r)) begin
                drive_value_nxt = low_level_r;
              end else if (CmpW'(phase_sum) <= lh_end) begin
                drive_value_nxt = high_level_r;
              end else begin
                // end of period: restart the phase, count the pulse, hold drive
                phase_time_nxt  = '0;
                pulses_done_nxt = pulses_done_r + 1'b1;
              end
            end else begin
              drive_value_nxt = low_level_r;
            end

            if (in_safety_low) begin
              alarm_time_nxt = alarm_sum;
              alarm = CmpW'(alarm_sum) > CmpW'(alarm_stop_time_r);
            end else begin
              alarm_time_nxt = '0;
            end

            // safety alarm wins over run completion
            if (alarm) begin
              cause = ptss_pkg::CAUSE_ALARM;
            end else if (pulses_done_nxt >= max_pulses_r) begin
              cause = ptss_pkg::CAUSE_DONE;
            end
            if (cause != ptss_pkg::CAUSE_NONE) begin
              run_active_nxt  = 1'b0;
              drive_value_nxt = '0;
            end
          end
        end
        default: begin
          // unused kind: report state unchanged
        end
      endcase
    end

    res_c.drive          = drive_value_nxt;
    res_c.pulse_count    = pulses_done_nxt;
    res_c.running        = run_active_nxt;
    res_c.shutdown_cause = cause;
  end

  // Configuration registers and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_enable_r  <= 1'b0;
      low_time_r        <= '0;
      high_time_r       <= '0;
      max_pulses_r      <= '0;
      alarm_stop_time_r <= '0;
      low_level_r       <= '0;
      high_level_r      <= '0;
      run_active_r      <= 1'b0;
      phase_time_r      <= '0;
      alarm_time_r      <= '0;
      pulses_done_r     <= '0;
      drive_value_r     <= '0;
    end else begin
      run_active_r  <= run_active_nxt;
      phase_time_r  <= phase_time_nxt;
      alarm_time_r  <= alarm_time_nxt;
      drive_value_r <= drive_value_nxt;
      // writing the initial count also preloads the pulse counter
      if (cfg_we &&
          (ptss_pkg::reg_idx_t'(cfg_index) == ptss_pkg::REG_INITIAL_COUNT)) begin
        pulses_done_r <= cfg_wdata;
      end else begin
        pulses_done_r <= pulses_done_nxt;
      end
      if (cfg_we) begin
        unique case (ptss_pkg::reg_idx_t'(cfg_index))
          ptss_pkg::REG_CHANNEL_ENABLE:  channel_enable_r  <= cfg_wdata[0];
          ptss_pkg::REG_LOW_TIME:        low_time_r        <= cfg_wdata;
          ptss_pkg::REG_HIGH_TIME:       high_time_r       <= cfg_wdata;
          ptss_pkg::REG_MAX_PULSES:      max_pulses_r      <= cfg_wdata;
          ptss_pkg::REG_INITIAL_COUNT: begin
            // only the pulse counter load above
          end
          ptss_pkg::REG_ALARM_STOP_TIME: alarm_stop_time_r <= cfg_wdata;
          ptss_pkg::REG_LOW_LEVEL:       low_level_r       <= cfg_wdata;
          ptss_pkg::REG_HIGH_LEVEL:      high_level_r      <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Result buffer: the output register feeds the port, the skid register catches a
  // beat accepted while the output register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_r) begin
          // advance the skid entry; no push possible while it is full
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= push;
        end
      end else if (push) begin
        if (out_valid_r) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (pop && skid_valid_r) begin
      out_r <= skid_r;
    end else if (push && (pop || !out_valid_r)) begin
      out_r <= res_c;
    end
    if (push && out_valid_r && !pop) begin
      skid_r <= res_c;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive          = out_r.drive;
  assign out_pulse_count    = out_r.pulse_count;
  assign out_running        = out_r.running;
  assign out_shutdown_cause = out_r.shutdown_cause;

endmodule
`default_nettype wire

### src/ptss_checker.sv
`default_nettype none
module ptss_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_we,
  input wire logic [2:0]  cfg_index,
  input wire logic [15:0] cfg_wdata,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_kind,
  input wire logic [15:0] in_elapsed_ms,
  input wire logic        in_safety_low,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_drive,
  input wire logic [15:0] out_pulse_count,
  input wire logic        out_running,
  input wire logic [1:0]  out_shutdown_cause
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) &&
    $stable(out_pulse_count) && $stable(out_running) && $stable(out_shutdown_cause))
    else $error("result beat changed while stalled");

  // a shutdown always stops the run and zeroes the drive
  a_shutdown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_shutdown_cause != ptss_pkg::CAUSE_NONE) |->
    !out_running && (out_drive == 16'd0))
    else $error("shutdown beat with live drive or run");

  // input back-pressure only while a result is pending
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result buffer");

  // after every accepted beat a result is valid on the next cycle
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

bind pulse_train_with_safety_stop ptss_checker u_ptss_checker (.*);
`default_nettype wire
